// File: sv/indexed_list_insert_delete_unit_macros.svh
// Assertion macros for the indexed list insert/delete unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ILID_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed list unit: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ILID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed list unit: next-cycle check failed");

`endif

// File: sv/ilid_pkg.sv
// Shared types and constants for the indexed list insert/delete unit.
// Used by the channel interfaces, the cell, the controller and the top level.
package ilid_pkg;

   localparam int CAPACITY_DEF    = 256;
   localparam int VALUE_WIDTH_DEF = 16;

   // Fixed field widths of the request and response beats.
   localparam int REQ_TYPE_W = 3;
   localparam int POS_W      = 9;
   localparam int ITEM_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 9;

   // Wide enough to address every cell up to the largest supported capacity.
   localparam int CELL_POS_W = 13;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_GET        = 3'd0,
      REQ_ADD_HEAD   = 3'd1,
      REQ_ADD_TAIL   = 3'd2,
      REQ_ADD_BEFORE = 3'd3,
      REQ_DELETE     = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_BAD_INDEX = 2'd1,
      STAT_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_LOAD,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic [CELL_POS_W-1:0]  pos;
   } cell_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ITEM_W-1:0]   read_value;
      logic [COUNT_W-1:0]  list_count;
   } rsp_data_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEEK
   } ilid_state_type;

endpackage

// File: sv/ilid_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on ilid_pkg for the field widths.
interface ilid_req_if import ilid_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [POS_W-1:0]      position;
   logic [ITEM_W-1:0]     item_value;

   modport source (output valid, req_type, position, item_value, input ready);
   modport sink   (input valid, req_type, position, item_value, output ready);
endinterface

interface ilid_rsp_if import ilid_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ITEM_W-1:0]   read_value;
   logic [COUNT_W-1:0]  list_count;

   modport source (output valid, status, read_value, list_count, input ready);
   modport sink   (input valid, status, read_value, list_count, output ready);
endinterface

// File: sv/ilid_cell.sv
// One cell of the list chain: holds one element and one read-line stage.
// Depends on ilid_pkg for the cell command struct.
module ilid_cell import ilid_pkg::*; #(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  cell_cmd_type           cmd,
   input  logic [VALUE_WIDTH-1:0] new_value,
   input  logic [VALUE_WIDTH-1:0] prev_value,
   input  logic [VALUE_WIDTH-1:0] next_value,
   input  logic [VALUE_WIDTH-1:0] next_read,
   output logic [VALUE_WIDTH-1:0] value,
   output logic [VALUE_WIDTH-1:0] read_out
);

   localparam logic [CELL_POS_W-1:0] MY_POS = CELL_POS_W'(INDEX);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] read_ff, read_in;
   logic                   is_at, is_after;

   assign is_at    = (cmd.pos == MY_POS);
   assign is_after = (MY_POS > cmd.pos);

   always_comb begin
      value_in = value_ff;
      read_in  = read_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (is_at) begin
               value_in = new_value;
            end else if (is_after) begin
               value_in = prev_value;
            end
         end
         CELL_DELETE: begin
            if (is_at || is_after) begin
               value_in = next_value;
            end
         end
         // The read line snapshots every element, then walks toward cell zero.
         CELL_LOAD:  read_in = value_ff;
         CELL_SHIFT: read_in = next_read;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      read_ff  <= read_in;
   end

   assign value    = value_ff;
   assign read_out = read_ff;

endmodule

// File: sv/ilid_ctrl.sv
// Request decoder, count register, get sequencer and response buffering.
// Depends on ilid_pkg, ilid_if and the assertion macro header.
`include "indexed_list_insert_delete_unit_macros.svh"

module ilid_ctrl import ilid_pkg::*; #(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   ilid_req_if.sink               req_chan,
   ilid_rsp_if.source             rsp_chan,
   output cell_cmd_type           cmd,
   output logic [VALUE_WIDTH-1:0] new_value,
   input  logic [VALUE_WIDTH-1:0] head_read
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int MW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   ilid_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [IW-1:0]  seek_ff, seek_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           pend_valid_ff, pend_valid_in;
   rsp_data_type   rsp_data_ff, rsp_data_in;
   rsp_data_type   pend_data_ff, pend_data_in;

   logic           req_ready;
   logic           done;
   rsp_data_type   done_data;
   logic [MW-1:0]  pos_ext, cnt_ext;
   logic           full;

   assign pos_ext   = MW'(req_chan.position);
   assign cnt_ext   = MW'(count_ff);
   assign full      = (count_ff == FULL_COUNT);
   assign new_value = VALUE_WIDTH'(req_chan.item_value);

   always_comb begin
      state_in             = state_ff;
      count_in             = count_ff;
      seek_in              = seek_ff;
      cmd.op               = CELL_HOLD;
      cmd.pos              = '0;
      req_ready            = 1'b0;
      done                 = 1'b0;
      done_data.status     = STAT_DONE;
      done_data.read_value = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !pend_valid_ff;
            if (req_chan.valid && req_ready) begin
               done = 1'b1;
               unique case (req_kind_type'(req_chan.req_type))
                  REQ_GET: begin
                     if (pos_ext < cnt_ext) begin
                        done     = 1'b0;
                        cmd.op   = CELL_LOAD;
                        seek_in  = IW'(req_chan.position);
                        state_in = ST_SEEK;
                     end else begin
                        done_data.status = STAT_BAD_INDEX;
                     end
                  end
                  REQ_ADD_HEAD: begin
                     if (full) begin
                        done_data.status = STAT_FULL;
                     end else begin
                        cmd.op   = CELL_INSERT;
                        cmd.pos  = '0;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  REQ_ADD_TAIL: begin
                     if (full) begin
                        done_data.status = STAT_FULL;
                     end else begin
                        cmd.op   = CELL_INSERT;
                        cmd.pos  = CELL_POS_W'(count_ff);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  REQ_ADD_BEFORE: begin
                     // The index check takes precedence over the full check.
                     if (pos_ext > cnt_ext) begin
                        done_data.status = STAT_BAD_INDEX;
                     end else if (full) begin
                        done_data.status = STAT_FULL;
                     end else begin
                        cmd.op   = CELL_INSERT;
                        cmd.pos  = CELL_POS_W'(req_chan.position);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  REQ_DELETE: begin
                     if (pos_ext < cnt_ext) begin
                        cmd.op   = CELL_DELETE;
                        cmd.pos  = CELL_POS_W'(req_chan.position);
                        count_in = count_ff - CW'(1);
                     end else begin
                        done_data.status = STAT_BAD_INDEX;
                     end
                  end
                  default: done_data.status = STAT_BAD_INDEX;
               endcase
            end
         end
         ST_SEEK: begin
            if (seek_ff == '0) begin
               done                 = 1'b1;
               done_data.read_value = ITEM_W'(head_read);
               state_in             = ST_IDLE;
            end else begin
               cmd.op  = CELL_SHIFT;
               seek_in = seek_ff - IW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
      done_data.list_count = COUNT_W'(count_in);

      // Output register plus one pending slot, so a new beat is taken while
      // a finished response is still waiting downstream.
      rsp_valid_in  = rsp_valid_ff;
      pend_valid_in = pend_valid_ff;
      rsp_data_in   = rsp_data_ff;
      pend_data_in  = pend_data_ff;
      if (done) begin
         if (!rsp_valid_ff || rsp_chan.ready) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = done_data;
         end else begin
            pend_valid_in = 1'b1;
            pend_data_in  = done_data;
         end
      end else if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_data_in   = pend_data_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seek_ff      <= seek_in;
      rsp_data_ff  <= rsp_data_in;
      pend_data_ff <= pend_data_in;
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_data_ff.status;
   assign rsp_chan.read_value = rsp_data_ff.read_value;
   assign rsp_chan.list_count = rsp_data_ff.list_count;

   `ILID_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT)
   `ILID_ASSERT_IMP(a_pend_behind_rsp, clock, reset, pend_valid_ff, rsp_valid_ff)
   `ILID_ASSERT_IMP(a_no_take_in_seek, clock, reset, state_ff == ST_SEEK, !req_ready)
   `ILID_ASSERT_NEXT(a_seek_ends, clock, reset, state_ff == ST_SEEK && seek_ff == '0, state_ff == ST_IDLE && rsp_valid_ff)

endmodule

// File: sv/indexed_list_insert_delete_unit.sv
// Latency: insert, delete and rejected requests answer from the output register, or
// from the pending slot while the output is held; a valid get answers once its value has
// walked down the read line of the cell chain one cell per cycle; no beat is taken meanwhile.
// Throughput: one non-get request per cycle while no response waits in the pending slot.
// Reset (synchronous, active high) empties the list and the response buffer; the element
// cells are not cleared, since a cell is always written before it is read.
module indexed_list_insert_delete_unit import ilid_pkg::*; #(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ilid_req_if.sink   req_chan,
   ilid_rsp_if.source rsp_chan
);

   cell_cmd_type           cmd;
   logic [VALUE_WIDTH-1:0] new_value;
   logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
   logic [VALUE_WIDTH-1:0] cell_read  [CAPACITY];

   ilid_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .cmd       (cmd),
      .new_value (new_value),
      .head_read (cell_read[0])
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] prev_value, next_value, next_read;

      // The ends of the chain feed back their own element; the read line
      // brings zeros in at the tail.
      if (i == 0) begin : g_first
         assign prev_value = cell_value[i];
      end else begin : g_prev
         assign prev_value = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_value = cell_value[i];
         assign next_read  = '0;
      end else begin : g_next
         assign next_value = cell_value[i+1];
         assign next_read  = cell_read[i+1];
      end

      ilid_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .new_value  (new_value),
         .prev_value (prev_value),
         .next_value (next_value),
         .next_read  (next_read),
         .value      (cell_value[i]),
         .read_out   (cell_read[i])
      );
   end

endmodule
